/* sv/b64d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, codes and the character lookup shared by the base64 decoder files.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
  localparam logic [7:0] PLUS_CHAR  = 8'h2B;  // '+'
  localparam logic [7:0] SLASH_CHAR = 8'h2F;  // '/'
  localparam logic [7:0] UPPER_LO   = 8'h41;  // 'A'
  localparam logic [7:0] UPPER_HI   = 8'h5A;  // 'Z'
  localparam logic [7:0] LOWER_LO   = 8'h61;  // 'a'
  localparam logic [7:0] LOWER_HI   = 8'h7A;  // 'z'
  localparam logic [7:0] DIGIT_LO   = 8'h30;  // '0'
  localparam logic [7:0] DIGIT_HI   = 8'h39;  // '9'
  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] PLUS_VAL   = 6'd62;
  localparam logic [5:0] SLASH_VAL  = 6'd63;

  localparam int MAX_RESULTS = 3;

  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_LEN  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    status_t    status;
  } result_t;

  // All results caused by one accepted character.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] res;    // res[0] goes out first
    logic [1:0]                count;  // 0..3
    logic                      eos;    // final result closes the text
  } bundle_t;

  // Bit 6 set: not a base64 character. '=' maps to zero.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (ch >= UPPER_LO && ch <= UPPER_HI) begin
        d = ch - UPPER_LO;
        sextet_of = {1'b0, d[5:0]};
      end else if (ch >= LOWER_LO && ch <= LOWER_HI) begin
        d = ch - LOWER_LO;
        sextet_of = {1'b0, d[5:0] + LOWER_BASE};
      end else if (ch >= DIGIT_LO && ch <= DIGIT_HI) begin
        d = ch - DIGIT_LO;
        sextet_of = {1'b0, d[5:0] + DIGIT_BASE};
      end else if (ch == PLUS_CHAR) begin
        sextet_of = {1'b0, PLUS_VAL};
      end else if (ch == SLASH_CHAR) begin
        sextet_of = {1'b0, SLASH_VAL};
      end else if (ch == PAD_CHAR) begin
        sextet_of = 7'd0;
      end else begin
        sextet_of = 7'b1000000;
      end
    end
  endfunction

endpackage

/* sv/b64d_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d channel interfaces
// Valid/ready channels for text characters and decoded results.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       end_of_text;

  modport source (output valid, text_char, end_of_text, input ready);
  modport sink   (input valid, text_char, end_of_text, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [1:0] status;
  logic       last_of_item;
  logic       end_of_stream;

  modport source (output valid, data_byte, status, last_of_item, end_of_stream,
                  input ready);
  modport sink   (input valid, data_byte, status, last_of_item, end_of_stream,
                  output ready);
endinterface

/* sv/b64d_group.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_group
// Group state of the decoder: collects sextets and builds the results of
// each character.
// ----------------------------------------------------------------------------
module b64d_group (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  logic [7:0]         text_char,
  input  logic               end_of_text,
  output b64d_pkg::bundle_t  bundle
);

  logic [17:0] sextets;
  logic [1:0]  position;
  logic        third_pad;
  logic        has_invalid;
  logic        failed;

  logic [17:0] sextets_next;
  logic [1:0]  position_next;
  logic        third_pad_next;
  logic        has_invalid_next;
  logic        failed_next;

  logic [6:0]  lookup;
  logic [5:0]  value;
  logic        is_pad;
  logic        bad;
  logic [23:0] quad;

  assign lookup = b64d_pkg::sextet_of(text_char);
  assign bad    = lookup[6];
  assign value  = bad ? 6'd0 : lookup[5:0];
  assign is_pad = (text_char == b64d_pkg::PAD_CHAR);
  assign quad   = {sextets, value};

  always_comb begin
    sextets_next     = sextets;
    position_next    = position;
    third_pad_next   = third_pad;
    has_invalid_next = has_invalid;
    failed_next      = failed;
    bundle           = '0;
    for (int i = 0; i < b64d_pkg::MAX_RESULTS; i++) begin
      bundle.res[i].status = b64d_pkg::ST_DATA;
    end

    if (!failed) begin
      if (position != 2'd3) begin
        sextets_next     = {sextets[11:0], value};
        position_next    = position + 2'd1;
        has_invalid_next = has_invalid | bad;
        if (position == 2'd2) begin
          third_pad_next = is_pad;
        end
        if (end_of_text) begin
          bundle.count         = 2'd1;
          bundle.res[0].status = b64d_pkg::ST_BAD_LEN;
        end
      end else begin
        if (has_invalid | bad) begin
          bundle.count         = 2'd1;
          bundle.res[0].status = b64d_pkg::ST_BAD_CHAR;
          failed_next          = 1'b1;
        end else begin
          // pad in third place drops the middle byte, so the low one moves up
          bundle.count             = 2'd1 + {1'b0, ~third_pad} + {1'b0, ~is_pad};
          bundle.res[0].data_byte  = quad[23:16];
          bundle.res[1].data_byte  = third_pad ? quad[7:0] : quad[15:8];
          bundle.res[2].data_byte  = quad[7:0];
        end
        sextets_next     = '0;
        position_next    = 2'd0;
        third_pad_next   = 1'b0;
        has_invalid_next = 1'b0;
      end
    end

    bundle.eos = end_of_text;

    if (end_of_text) begin
      sextets_next     = '0;
      position_next    = 2'd0;
      third_pad_next   = 1'b0;
      has_invalid_next = 1'b0;
      failed_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sextets     <= '0;
      position    <= 2'd0;
      third_pad   <= 1'b0;
      has_invalid <= 1'b0;
      failed      <= 1'b0;
    end else if (take) begin
      sextets     <= sextets_next;
      position    <= position_next;
      third_pad   <= third_pad_next;
      has_invalid <= has_invalid_next;
      failed      <= failed_next;
    end
  end

endmodule

/* sv/base64_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder (standard alphabet), one character per transfer.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Payload                                          Per transfer
// text     in   text_char[7:0], end_of_text                      one character
// result   out  data_byte[7:0], status[1:0], last_of_item,       one result
//               end_of_stream
//
// A character is taken every cycle while the two-slot result queue has room;
// its results are registered at the edge that takes it and shown from the next
// cycle on. While result.ready is high the result port gives one result per
// cycle, so the up to three bytes of a four-character group drain as the next
// group comes in and input runs at one character per cycle. Characters that
// make no result (the first three of a group, or anything after an error)
// never enter the queue. text.ready depends only on queue fill, not on
// result.ready. rst (synchronous) clears group state and empties the queue.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  b64d_in_if.sink     text,
  b64d_out_if.source  result
);

  b64d_pkg::bundle_t new_bundle;
  logic              take;

  // Queue of per-character result bundles.
  b64d_pkg::bundle_t slots [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic [1:0]        drain_idx;   // next result within the head bundle

  b64d_pkg::bundle_t head;
  logic              push;
  logic              pop;
  logic              head_last;

  assign text.ready = (fill != 2'd2);
  assign take       = text.valid & text.ready;

  b64d_group u_group (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .text_char   (text.text_char),
    .end_of_text (text.end_of_text),
    .bundle      (new_bundle)
  );

  // End-marked characters after an error give nothing and push nothing.
  assign push = take & (new_bundle.count != 2'd0);

  assign head      = slots[rd_ptr];
  assign head_last = (drain_idx == head.count - 2'd1);
  assign pop       = result.valid & result.ready & head_last;

  assign result.valid         = (fill != 2'd0);
  assign result.data_byte     = head.res[drain_idx].data_byte;
  assign result.status        = head.res[drain_idx].status;
  assign result.last_of_item  = head_last;
  assign result.end_of_stream = head_last & head.eos;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= 1'b0;
      rd_ptr    <= 1'b0;
      fill      <= 2'd0;
      drain_idx <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (result.valid & result.ready) begin
        if (head_last) begin
          rd_ptr    <= ~rd_ptr;
          drain_idx <= 2'd0;
        end else begin
          drain_idx <= drain_idx + 2'd1;
        end
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* sim/base64_stream_decoder_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_checker
// Watches the text and result channels of the decoder, predicts the decoded
// bytes and error reports of every character transfer and compares each
// result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module base64_stream_decoder_checker (
  input  logic clk,
  input  logic rst,
  b64d_in_if   text,
  b64d_out_if  result,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count,
  output int   error_count
);

  typedef struct {
    logic [7:0]          data_byte;
    b64d_pkg::status_t   status;
    logic                last_of_item;
    logic                end_of_stream;
  } decoded_t;

  decoded_t decoded_q[$];

  // Decoder state as seen from outside
  logic [17:0] grp_bits;
  logic [1:0]  grp_pos;
  logic        pad_third;
  logic        grp_bad;
  logic        text_failed;

  initial begin
    fail_count    = 0;
    pending_count = 0;
    checked_count = 0;
    error_count   = 0;
  end

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] char_to_sextet(input logic [7:0] ch);
    logic [7:0] v;
    v = 8'd64;
    if (ch >= b64d_pkg::UPPER_LO && ch <= b64d_pkg::UPPER_HI)
      v = ch - b64d_pkg::UPPER_LO;
    if (ch >= b64d_pkg::LOWER_LO && ch <= b64d_pkg::LOWER_HI)
      v = ch - b64d_pkg::LOWER_LO + {2'b00, b64d_pkg::LOWER_BASE};
    if (ch >= b64d_pkg::DIGIT_LO && ch <= b64d_pkg::DIGIT_HI)
      v = ch - b64d_pkg::DIGIT_LO + {2'b00, b64d_pkg::DIGIT_BASE};
    if (ch == b64d_pkg::PLUS_CHAR)  v = {2'b00, b64d_pkg::PLUS_VAL};
    if (ch == b64d_pkg::SLASH_CHAR) v = {2'b00, b64d_pkg::SLASH_VAL};
    if (ch == b64d_pkg::PAD_CHAR)   v = 8'd0;
    return v[6:0];
  endfunction

  function automatic void clear_group();
    grp_bits  = '0;
    grp_pos   = '0;
    pad_third = 1'b0;
    grp_bad   = 1'b0;
  endfunction

  // Works out the results of one character and queues them in order.
  function automatic void decode_char(input logic [7:0] ch, input logic eot);
    decoded_t    res [0:2];
    int          n;
    logic [6:0]  sx;
    logic        is_pad;
    logic [23:0] quad;
    n = 0;
    if (!text_failed) begin
      sx     = char_to_sextet(ch);
      is_pad = (ch == b64d_pkg::PAD_CHAR);
      if (sx[6]) begin
        grp_bad = 1'b1;
        sx      = '0;
      end
      if (grp_pos != 2'd3) begin
        grp_bits = {grp_bits[11:0], sx[5:0]};
        if (grp_pos == 2'd2) pad_third = is_pad;
        grp_pos = grp_pos + 2'd1;
        if (eot) begin
          res[n] = '{8'h00, b64d_pkg::ST_BAD_LEN, 1'b0, 1'b0};
          n++;
        end
      end else begin
        if (grp_bad) begin
          res[n] = '{8'h00, b64d_pkg::ST_BAD_CHAR, 1'b0, 1'b0};
          n++;
          text_failed = 1'b1;
        end else begin
          quad   = {grp_bits, sx[5:0]};
          res[n] = '{quad[23:16], b64d_pkg::ST_DATA, 1'b0, 1'b0};
          n++;
          if (!pad_third) begin
            res[n] = '{quad[15:8], b64d_pkg::ST_DATA, 1'b0, 1'b0};
            n++;
          end
          if (!is_pad) begin
            res[n] = '{quad[7:0], b64d_pkg::ST_DATA, 1'b0, 1'b0};
            n++;
          end
        end
        clear_group();
      end
    end
    if (n > 0) begin
      res[n-1].last_of_item  = 1'b1;
      res[n-1].end_of_stream = eot;
    end
    for (int i = 0; i < n; i++) decoded_q.push_back(res[i]);
    if (eot) begin
      clear_group();
      text_failed = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("result with nothing pending, data_byte",
                      int'(result.data_byte), 0);
    end else begin
      want = decoded_q.pop_front();
      checked_count++;
      if (want.status != b64d_pkg::ST_DATA) error_count++;
      if (result.data_byte !== want.data_byte)
        report_mismatch("data_byte", int'(result.data_byte), int'(want.data_byte));
      if (result.status !== want.status)
        report_mismatch("status", int'(result.status), int'(want.status));
      if (result.last_of_item !== want.last_of_item)
        report_mismatch("last_of_item", int'(result.last_of_item),
                        int'(want.last_of_item));
      if (result.end_of_stream !== want.end_of_stream)
        report_mismatch("end_of_stream", int'(result.end_of_stream),
                        int'(want.end_of_stream));
    end
  endtask

  // A result never comes from the character taken at the same edge, so the
  // compare goes first.
  always @(posedge clk) begin
    if (rst) begin
      clear_group();
      text_failed = 1'b0;
      decoded_q.delete();
    end else begin
      if (result.valid && result.ready) check_result();
      if (text.valid && text.ready) decode_char(text.text_char, text.end_of_text);
    end
    pending_count = decoded_q.size();
  end

endmodule

/* sim/base64_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Drives base64 texts into the decoder: a short directed set (padding forms,
// all-zero and all-one bytes, bad characters, short texts), then random
// well-formed, truncated, corrupted and noise texts. Both channels idle in
// random bursts. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;

  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer on any channel
  localparam int LONG_HOLD   = 80;    // receiver back-pressure stretch

  logic clk;
  logic rst;

  b64d_in_if  text_ch ();
  b64d_out_if result_ch ();

  int fail_count;
  int pending_count;
  int checked_count;
  int error_count;

  base64_stream_decoder u_top (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  base64_stream_decoder_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .text          (text_ch),
    .result        (result_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .error_count   (error_count)
  );

  // Idle controls, shared between the sender and the receiver processes
  bit tx_idle_on;
  bit rx_idle_on;
  bit rx_long_hold;   // request: receiver holds off for a LONG_HOLD stretch

  int chars_sent;
  int texts_sent;
  int quiet_cycles;

  logic [7:0] txt[$];  // text being assembled before it is sent

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hang shows up as a long stretch with no transfer at all.
  // --------------------------------------------------------------------------
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results still pending",
                 QUIET_LIMIT, pending_count);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready changes once per falling edge. A running stall ends first;
  // then a long hold request wins over starting a random stall burst.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_long_hold) begin
        rx_long_hold     = 1'b0;
        result_ch.ready <= 1'b0;
        stall_left       = LONG_HOLD - 1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        stall_left       = $urandom_range(0, 14);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers
  // --------------------------------------------------------------------------

  // One character; returns after the edge that takes it. valid stays high so
  // back-to-back characters go one per cycle while text.ready stays high.
  task automatic send_char(input logic [7:0] ch, input logic eot);
    int gap;
    if (tx_idle_on && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk);
      text_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    text_ch.valid       <= 1'b1;
    text_ch.text_char   <= ch;
    text_ch.end_of_text <= eot;
    do @(posedge clk); while (!(text_ch.valid && text_ch.ready));
    chars_sent++;
  endtask

  // Sends the assembled text, end flag on the last character if asked.
  task automatic send_text(input bit with_eot);
    for (int i = 0; i < txt.size(); i++)
      send_char(txt[i], with_eot && (i == txt.size() - 1));
    txt.delete();
    texts_sent++;
  endtask

  // Sender pause: drop valid and wait until every pending result is out.
  task automatic wait_drained();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    if (v < b64d_pkg::LOWER_BASE) return b64d_pkg::UPPER_LO + {2'b00, v};
    if (v < b64d_pkg::DIGIT_BASE)
      return b64d_pkg::LOWER_LO + {2'b00, v - b64d_pkg::LOWER_BASE};
    if (v < b64d_pkg::PLUS_VAL)
      return b64d_pkg::DIGIT_LO + {2'b00, v - b64d_pkg::DIGIT_BASE};
    if (v == b64d_pkg::PLUS_VAL) return b64d_pkg::PLUS_CHAR;
    return b64d_pkg::SLASH_CHAR;
  endfunction

  // Mostly alphabet, some pads, some raw bytes (covers the high bit).
  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)  return sextet_char(6'($urandom_range(0, 63)));
    if (pick == 7) return b64d_pkg::PAD_CHAR;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_string(input string s);
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
  endfunction

  // Four characters, the rest alphabet; pads = 1 ends in one '=', pads = 2 in two.
  function automatic void push_group(input int pads);
    for (int i = 0; i < 4; i++)
      if (i >= 4 - pads) txt.push_back(b64d_pkg::PAD_CHAR);
      else txt.push_back(sextet_char(6'($urandom_range(0, 63))));
  endfunction

  function automatic void push_clean_text(input int groups);
    for (int g = 0; g < groups - 1; g++) push_group(0);
    push_group($urandom_range(0, 2));
  endfunction

  // Most texts are well formed; the rest are cut short, corrupted, pure noise,
  // or carry on into the next text without an end marker.
  task automatic random_text();
    int kind;
    int len;
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      len = $urandom_range(1, 9);
      repeat (len) txt.push_back(random_char());
    end else begin
      push_clean_text($urandom_range(1, 4));
      if (kind == 6) begin
        repeat ($urandom_range(1, 3)) void'(txt.pop_back());
      end else if (kind == 7) begin
        txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
    send_text(kind != 9);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    text_ch.valid       = 1'b0;
    text_ch.text_char   = 8'h00;
    text_ch.end_of_text = 1'b0;
    tx_idle_on          = 1'b1;
    rx_idle_on          = 1'b1;
    rx_long_hold        = 1'b0;
    chars_sent          = 0;
    texts_sent          = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: three-, one- and two-byte groups, then 0xFF bytes
    push_string("TWFuTQ==TWE=////");
    send_text(1);
    // pads in first and second place count as zero sextets: three 0x00 bytes
    push_string("==AA");
    send_text(1);
    // bad character reported at group end; the end-marked 'z' is then ignored
    push_string("A*AAz");
    send_text(1);
    // short text whose partial group also holds a bad character
    push_string("A");
    txt.push_back(8'hFF);
    send_text(1);

    // Random texts with idling toggled per text
    while (chars_sent < 100) begin
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      random_text();
    end

    // Back-pressure: receiver holds off while full groups keep coming, so
    // the result queue fills and text.ready drops.
    tx_idle_on   = 1'b0;
    @(negedge clk);
    text_ch.valid <= 1'b0;
    rx_long_hold = 1'b1;
    while (rx_long_hold) @(negedge clk);
    push_clean_text(6);
    send_text(1);

    // Sender pause until all results are out
    wait_drained();

    while (chars_sent < 160) begin
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      random_text();
    end

    // Final stretch at full rate on both sides
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (chars_sent < 196) random_text();
    // close any text left open by the last one
    push_clean_text(1);
    send_text(1);

    wait_drained();
    repeat (10) @(posedge clk);

    $display("Covered %0d characters in %0d texts; %0d results checked, %0d error reports.",
             chars_sent, texts_sent, checked_count, error_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
